@@ rtl/sbsw_pkg.sv @@
// Shared types, constants and a helper function of the band and serial word writer.
// Has no dependencies; every other file of the block but sbsw_fifo imports it.
`default_nettype none

package sbsw_pkg;

	// Width of the widest configuration register.
	localparam int CFG_DATA_W = 16;
	localparam int CFG_ADDR_W = 2;

	// Register indices of the configuration port.
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_GAIN_CODE   = 2'd0,
		REG_ATTENUATOR  = 2'd1,
		REG_PREFIX_BITS = 2'd2,
		REG_FREQ_OFFSET = 2'd3
	} cfg_reg_t;

	localparam int FREQ_W   = 16;
	localparam int GAIN_W   = 3;
	localparam int BAND_W   = 3;
	localparam int PFX_W    = 3;
	localparam int DIV_W    = 16;
	localparam int CTRL_W   = 8;
	localparam int NIB_W    = 4;
	localparam int SUM_W    = FREQ_W + 1;
	localparam int DBL_W    = SUM_W + 1;
	localparam int RECIP_W  = 16;
	localparam int PROD_W   = DBL_W + RECIP_W;
	localparam int RECIP_SH = 18;

	// floor(x / 5) equals (x * 52429) >> 18 for every x below 2**18.
	localparam logic [RECIP_W-1:0] RECIP_5 = 16'd52429;

	localparam logic [GAIN_W-1:0]  GAIN_RESET   = 3'd0;
	localparam logic               ATTEN_RESET  = 1'b0;
	localparam logic [PFX_W-1:0]   PREFIX_RESET = 3'd4;
	localparam logic [FREQ_W-1:0]  OFFSET_RESET = 16'd63000;

	localparam logic [NIB_W-1:0] NIB_XOR = 4'hB;

	// Band thresholds in kHz; entry zero is never tested.
	localparam logic [FREQ_W-1:0] BAND_EDGE [8] = '{
		16'd0, 16'd3555, 16'd8675, 16'd13795,
		16'd18915, 16'd24035, 16'd29155, 16'd34280
	};

	typedef struct packed {
		logic [NIB_W-1:0] first;
		logic [NIB_W-1:0] second;
		logic [NIB_W-1:0] third;
		logic [NIB_W-1:0] fourth;
	} nib_set_t;

	typedef struct packed {
		logic              port_select;
		logic [CTRL_W-1:0] control_byte;
		nib_set_t          nib;
		logic              last;
	} res_t;

	// Four control port writes for one serial bit. The latch variant uses the raised
	// code less four on the third write.
	function automatic nib_set_t nib_for_bit(input logic b, input logic latch);
		nib_set_t         n;
		logic [NIB_W-1:0] base;
		base     = {2'b01, b, 1'b0};
		n.first  = base ^ NIB_XOR;
		n.second = {2'b01, b, 1'b1} ^ NIB_XOR;
		n.third  = latch ? ({2'b00, b, 1'b1} ^ NIB_XOR) : n.second;
		n.fourth = n.first;
		return n;
	endfunction

endpackage

`default_nettype wire

@@ rtl/sbsw_front.sv @@
// Front end: accepts frequency requests, finds the band, builds the control
// byte and computes the divider in two pipeline stages. Depends on sbsw_pkg.
`default_nettype none

module sbsw_front #(
	parameter int DIVIDER_BITS = 16,
	parameter int PREFIX_LEN   = 3,
	parameter int JOB_W        = 8 + PREFIX_LEN + DIVIDER_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [sbsw_pkg::GAIN_W-1:0]   gain_code,
	input  wire logic                          attenuator_on,
	input  wire logic [sbsw_pkg::PFX_W-1:0]    prefix_bits,
	input  wire logic [sbsw_pkg::FREQ_W-1:0]   frequency_offset,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [sbsw_pkg::FREQ_W-1:0]   frequency_khz,
	output logic                               push_valid,
	input  wire logic                          push_ready,
	output logic [JOB_W-1:0]                   push_data
);
	import sbsw_pkg::*;

	logic                  v_s1;
	logic [FREQ_W-1:0]     f_s1;
	logic                  v_s2;
	logic [CTRL_W-1:0]     ctrl_s2;
	logic [PFX_W-1:0]      pfx_s2;
	logic [PROD_W-1:0]     prod_s2;

	logic                  s2_free;
	logic                  mv1;
	logic [BAND_W-1:0]     band_c;
	logic [SUM_W-1:0]      sum_c;
	logic [DBL_W-1:0]      dbl_c;
	logic [PROD_W-1:0]     prod_c;
	logic [DIV_W-1:0]      div_c;
	logic [PREFIX_LEN+PFX_W-1:0]   pfx_ext;
	logic [DIVIDER_BITS+DIV_W-1:0] div_ext;

	assign s2_free  = !v_s2 || push_ready;
	assign mv1      = v_s1 && s2_free;
	assign in_ready = !v_s1 || s2_free;

	always_comb begin
		band_c = '0;
		for (int i = 1; i < 8; i++) begin
			if (f_s1 > BAND_EDGE[i]) begin
				band_c = BAND_W'(i);
			end
		end
	end

	assign sum_c  = {1'b0, f_s1} + {1'b0, frequency_offset};
	assign dbl_c  = {sum_c, 1'b0};
	assign prod_c = PROD_W'(dbl_c) * PROD_W'(RECIP_5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (s2_free) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			f_s1 <= frequency_khz;
		end
		if (mv1) begin
			ctrl_s2 <= {1'b1, gain_code, band_c, attenuator_on};
			pfx_s2  <= prefix_bits;
			prod_s2 <= prod_c;
		end
	end

	// Bits of the prefix and divider beyond their natural widths go out as zero.
	assign div_c   = prod_s2[RECIP_SH +: DIV_W];
	assign pfx_ext = {{PREFIX_LEN{1'b0}}, pfx_s2};
	assign div_ext = {{DIVIDER_BITS{1'b0}}, div_c};

	assign push_valid = v_s2;
	assign push_data  = {ctrl_s2, pfx_ext[PREFIX_LEN-1:0], div_ext[DIVIDER_BITS-1:0]};

endmodule

`default_nettype wire

@@ rtl/sbsw_fifo.sv @@
// Short request queue between the front end and the serialiser.
// Self-contained; uses no package.
`default_nettype none

module sbsw_fifo #(
	parameter int WIDTH = 27,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output logic [WIDTH-1:0]      pop_data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

@@ rtl/sbsw_back.sv @@
// Serialiser: takes one queued request, delivers its control byte, then every serial
// bit as one result per cycle while its output register is free. Depends on sbsw_pkg.
`default_nettype none

module sbsw_back #(
	parameter int DIVIDER_BITS = 16,
	parameter int PREFIX_LEN   = 3,
	parameter int JOB_W        = 8 + PREFIX_LEN + DIVIDER_BITS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             pop_valid,
	output logic                  pop_ready,
	input  wire logic [JOB_W-1:0] pop_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output sbsw_pkg::res_t        out_res
);
	import sbsw_pkg::*;

	localparam int SEQ_W   = PREFIX_LEN + DIVIDER_BITS;
	localparam int SEQ_LEN = 1 + SEQ_W;
	localparam int CNT_W   = $clog2(SEQ_LEN);

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CTRL_W-1:0] ctrl_q;
	logic [SEQ_W-1:0]  shift_q;
	logic              out_valid_q;
	res_t              res_q;

	logic              out_free;
	logic              emit;
	logic              is_last;
	logic              pop;
	res_t              res_c;

	assign out_free  = !out_valid_q || out_ready;
	assign emit      = busy_q && out_free;
	assign is_last   = cnt_q == CNT_W'(SEQ_LEN - 1);
	assign pop       = pop_valid && (!busy_q || (emit && is_last));
	assign pop_ready = !busy_q || (emit && is_last);

	always_comb begin
		res_c.port_select  = cnt_q != '0;
		res_c.control_byte = res_c.port_select ? '0 : ctrl_q;
		res_c.nib          = res_c.port_select ? nib_for_bit(shift_q[SEQ_W-1], is_last) : '0;
		res_c.last         = is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= emit;
			end
			if (pop) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (emit) begin
				cnt_q <= cnt_q + 1'b1;
				if (is_last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ctrl_q  <= pop_data[JOB_W-1 -: CTRL_W];
			shift_q <= pop_data[SEQ_W-1:0];
		end else if (emit && cnt_q != '0) begin
			shift_q <= {shift_q[SEQ_W-2:0], 1'b0};
		end
		if (emit) begin
			res_q <= res_c;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = res_q;

endmodule

`default_nettype wire

@@ rtl/synth_band_and_serial_word_writer_top.sv @@
// Top level of the band and serial word writer: configuration registers, front end,
// request queue and serialiser. Depends on sbsw_pkg, sbsw_front, sbsw_fifo and sbsw_back.
//
// Each accepted request carries a sounding frequency in kHz and produces a burst of
// 1 + PREFIX_LEN + DIVIDER_BITS results (20 with the default parameters): first the
// control byte for the data port, built from the attenuator flag, the band (the
// highest of seven thresholds that the frequency exceeds, zero if none), the gain
// code and a fixed top bit; then the register select prefix and the divider
// floor(2*(f + offset)/5), each bit most significant first as four control port
// nibbles, with the latch code in the third nibble of the final divider bit and
// last raised on that result. The serialiser delivers one result per clock while
// its output register is free, which sets the block's rate, and takes the next
// request as it delivers the last result of the one before. The front end takes a
// new request every cycle while the queue has room, so requests keep arriving while
// an earlier burst is still being delivered. When the block is otherwise empty, a
// request is registered in the front end, the queue and the serialiser before its
// first result reaches the output register. The divider uses a constant reciprocal
// multiply rather than a divider. Configuration registers are written through a
// plain write port and must only be changed while no request is in flight.
`default_nettype none

module synth_band_and_serial_word_writer_top #(
	parameter int DIVIDER_BITS = 16,
	parameter int PREFIX_LEN   = 3,
	parameter int QUEUE_DEPTH  = 2
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [sbsw_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  wire logic [sbsw_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [sbsw_pkg::FREQ_W-1:0]       frequency_khz,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   port_select,
	output logic [sbsw_pkg::CTRL_W-1:0]            control_byte,
	output logic [sbsw_pkg::NIB_W-1:0]             nibble_first,
	output logic [sbsw_pkg::NIB_W-1:0]             nibble_second,
	output logic [sbsw_pkg::NIB_W-1:0]             nibble_third,
	output logic [sbsw_pkg::NIB_W-1:0]             nibble_fourth,
	output logic                                   last
);
	import sbsw_pkg::*;

	// A queued request holds the control byte and the serial bit stream.
	localparam int JOB_W = CTRL_W + PREFIX_LEN + DIVIDER_BITS;

	logic [GAIN_W-1:0] gain_code_q;
	logic              attenuator_on_q;
	logic [PFX_W-1:0]  prefix_bits_q;
	logic [FREQ_W-1:0] frequency_offset_q;

	logic              push_valid;
	logic              push_ready;
	logic [JOB_W-1:0]  push_data;
	logic              pop_valid;
	logic              pop_ready;
	logic [JOB_W-1:0]  pop_data;
	res_t              out_res;

	// Configuration registers; writes to an index without a register fall through.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_code_q        <= GAIN_RESET;
			attenuator_on_q    <= ATTEN_RESET;
			prefix_bits_q      <= PREFIX_RESET;
			frequency_offset_q <= OFFSET_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_GAIN_CODE: begin
					gain_code_q <= cfg_wdata[GAIN_W-1:0];
				end
				REG_ATTENUATOR: begin
					attenuator_on_q <= cfg_wdata[0];
				end
				REG_PREFIX_BITS: begin
					prefix_bits_q <= cfg_wdata[PFX_W-1:0];
				end
				REG_FREQ_OFFSET: begin
					frequency_offset_q <= cfg_wdata[FREQ_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// The front end classifies the request and computes the divider.
	sbsw_front #(
		.DIVIDER_BITS (DIVIDER_BITS),
		.PREFIX_LEN   (PREFIX_LEN),
		.JOB_W        (JOB_W)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.gain_code        (gain_code_q),
		.attenuator_on    (attenuator_on_q),
		.prefix_bits      (prefix_bits_q),
		.frequency_offset (frequency_offset_q),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.frequency_khz    (frequency_khz),
		.push_valid       (push_valid),
		.push_ready       (push_ready),
		.push_data        (push_data)
	);

	// The queue lets the front end run ahead while a burst is being delivered.
	sbsw_fifo #(
		.WIDTH (JOB_W),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// The serialiser walks each request through its results.
	sbsw_back #(
		.DIVIDER_BITS (DIVIDER_BITS),
		.PREFIX_LEN   (PREFIX_LEN),
		.JOB_W        (JOB_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign port_select   = out_res.port_select;
	assign control_byte  = out_res.control_byte;
	assign nibble_first  = out_res.nib.first;
	assign nibble_second = out_res.nib.second;
	assign nibble_third  = out_res.nib.third;
	assign nibble_fourth = out_res.nib.fourth;
	assign last          = out_res.last;

	// The final result of a burst is always a nibble write carrying the latch code.
	a_last_is_latch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> port_select && (nibble_third != nibble_second))
		else $error("final result lacks the latch nibble");

	// A control byte result always has its top bit set and its nibbles cleared.
	a_ctrl_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !port_select |-> control_byte[CTRL_W-1] && (nibble_first == '0))
		else $error("malformed control byte result");

	// A nibble result repeats its first write as its fourth and carries no control byte.
	a_nib_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && port_select |-> (nibble_fourth == nibble_first) && (control_byte == '0))
		else $error("malformed nibble result");

	// A delivered final result is followed either by nothing or by a control byte.
	a_burst_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last ##1 out_valid |-> !port_select)
		else $error("burst did not start with a control byte");

endmodule

`default_nettype wire

@@ tb/sv/tb_synth_band_and_serial_word_writer_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for synth_band_and_serial_word_writer_top.
// Depends on sbsw_pkg and the block's RTL; holds its own scoreboard and stimulus.

module tb_synth_band_and_serial_word_writer_top;
	import sbsw_pkg::*;

	// Cycles with no request and no result accepted before the run is declared hung.
	// The long receiver hold-off below is far shorter, so this leaves ample margin.
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER  = 2500;
	localparam int PHASE_REQS  = 67;

	// Corner frequencies: zero, both sides of every band threshold, the top of
	// the range and two alternating bit patterns.
	localparam logic [FREQ_W-1:0] CORNER_KHZ [19] = '{
		16'd0, 16'd1, 16'd3555, 16'd3556, 16'd8675, 16'd8676, 16'd13795,
		16'd13796, 16'd18915, 16'd18916, 16'd24035, 16'd24036, 16'd29155,
		16'd29156, 16'd34280, 16'd34281, 16'd65535, 16'h5555, 16'hAAAA
	};

	// Scoreboard: a private copy of the registers, the prediction of the port
	// write burst for each accepted request and the queue of writes still owed.
	class port_write_board;
		res_t             owed_writes[$];
		logic [GAIN_W-1:0] gain_code;
		logic              attenuator_on;
		logic [PFX_W-1:0]  prefix_bits;
		logic [FREQ_W-1:0] freq_offset;
		int unsigned       band_floor[8];
		int                mismatches;
		int                seen;

		function new();
			band_floor    = '{0, 3555, 8675, 13795, 18915, 24035, 29155, 34280};
			gain_code     = 3'd0;
			attenuator_on = 1'b0;
			prefix_bits   = 3'd4;
			freq_offset   = 16'd63000;
			mismatches    = 0;
			seen          = 0;
		endfunction

		// Values wider than a register are cut to its width.
		function void set_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
			REG_GAIN_CODE:   gain_code = value[GAIN_W-1:0];
			REG_ATTENUATOR:  attenuator_on = value[0];
			REG_PREFIX_BITS: prefix_bits = value[PFX_W-1:0];
			REG_FREQ_OFFSET: freq_offset = value[FREQ_W-1:0];
			default: ;
			endcase
		endfunction

		// One serial bit as four control port nibbles. The line code is 4 for a
		// zero and 6 for a one, plus one while the clock is raised; the latch
		// write on the final bit uses the raised code less four.
		function res_t serial_bit(logic b, logic closing);
			res_t             r;
			logic [NIB_W-1:0] code;
			code            = b ? 4'd6 : 4'd4;
			r.port_select   = 1'b1;
			r.control_byte  = '0;
			r.nib.first     = code ^ 4'hB;
			r.nib.second    = (code + 4'd1) ^ 4'hB;
			r.nib.third     = closing ? ((code - 4'd3) ^ 4'hB) : r.nib.second;
			r.nib.fourth    = r.nib.first;
			r.last          = closing;
			return r;
		endfunction

		function void predict_port_writes(logic [FREQ_W-1:0] f);
			res_t        ctl;
			int          band;
			int          i;
			logic [17:0] doubled;
			logic [15:0] divider;
			band = 0;
			for (i = 1; i < 8; i++)
				if (f > band_floor[i])
					band = i;
			// 2*(f + offset) never exceeds 262140, so eighteen bits hold it.
			doubled = (18'(f) + 18'(freq_offset)) << 1;
			divider = 16'(doubled / 18'd5);
			ctl = '0;
			ctl.control_byte = 8'(attenuator_on) + 8'(band * 2) + 8'({gain_code, 4'b0})
				+ 8'h80;
			owed_writes.push_back(ctl);
			for (i = PFX_W - 1; i >= 0; i--)
				owed_writes.push_back(serial_bit(prefix_bits[i], 1'b0));
			for (i = DIV_W - 1; i >= 0; i--)
				owed_writes.push_back(serial_bit(divider[i], i == 0));
		endfunction

		function string describe(res_t r);
			return $sformatf("port %0b ctl %02h nib %h %h %h %h last %0b", r.port_select,
				r.control_byte, r.nib.first, r.nib.second, r.nib.third, r.nib.fourth,
				r.last);
		endfunction

		// Prints at most a few dozen lines, but counts every mismatch.
		task report(string what);
			mismatches++;
			if (mismatches <= 30)
				$display("MISMATCH: %s", what);
		endtask

		task check_port_write(res_t got);
			res_t want;
			seen++;
			if (owed_writes.size() == 0) begin
				report($sformatf("result %0d arrived unrequested: %s", seen, describe(got)));
			end else begin
				want = owed_writes.pop_front();
				if (got !== want)
					report($sformatf("result %0d: got %s, expected %s", seen,
						describe(got), describe(want)));
			end
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  in_valid;
	logic                  in_ready;
	logic [FREQ_W-1:0]     frequency_khz;
	logic                  out_valid;
	logic                  out_ready;
	logic                  port_select;
	logic [CTRL_W-1:0]     control_byte;
	logic [NIB_W-1:0]      nibble_first;
	logic [NIB_W-1:0]      nibble_second;
	logic [NIB_W-1:0]      nibble_third;
	logic [NIB_W-1:0]      nibble_fourth;
	logic                  last;

	port_write_board board;
	int              burst_left;

	synth_band_and_serial_word_writer_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.frequency_khz (frequency_khz),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.port_select   (port_select),
		.control_byte  (control_byte),
		.nibble_first  (nibble_first),
		.nibble_second (nibble_second),
		.nibble_third  (nibble_third),
		.nibble_fourth (nibble_fourth),
		.last          (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Frequencies for the random part: mostly uniform over the whole range, with
	// a good share just around the band thresholds and at the very ends.
	function automatic logic [FREQ_W-1:0] pick_frequency();
		logic [FREQ_W-1:0] f;
		case ($urandom_range(0, 9))
		0, 1: f = 16'(board.band_floor[$urandom_range(1, 7)]) - 16'd1
			+ 16'($urandom_range(0, 2));
		2: begin
			case ($urandom_range(0, 2))
			0: f = 16'd0;
			1: f = 16'hFFFF;
			default: f = 16'($urandom_range(0, 16));
			endcase
		end
		default: f = 16'($urandom_range(0, 65535));
		endcase
		return f;
	endfunction

	// One register write per clock; the write enable stays high across a batch
	// and is lowered once by the caller afterwards.
	task automatic write_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= value;
		board.set_register(idx, value);
		@(posedge clk);
	endtask

	// Writes all four registers. With noisy set, the unused upper bits of the
	// narrow registers carry random junk, which the block must discard.
	task automatic apply_settings(int gain, int atten, int prefix, int offset, bit noisy);
		logic [CFG_DATA_W-1:0] junk;
		junk = noisy ? 16'($urandom) : 16'd0;
		write_register(REG_GAIN_CODE, {junk[15:3], 3'(gain)});
		write_register(REG_ATTENUATOR, {junk[15:1], 1'(atten)});
		write_register(REG_PREFIX_BITS, {junk[15:3], 3'(prefix)});
		write_register(REG_FREQ_OFFSET, 16'(offset));
		cfg_we    <= 1'b0;
		cfg_wdata <= 16'($urandom);
	endtask

	// Offers one request and holds it until the block takes it. Requests go out
	// in bursts; between bursts the sender falls silent for a random while, and
	// some bursts are long enough to keep the input busy for a good stretch.
	task automatic send_request(logic [FREQ_W-1:0] f);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				in_valid      <= 1'b0;
				frequency_khz <= 16'($urandom);
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid      <= 1'b1;
		frequency_khz <= f;
		do
			@(posedge clk);
		while (!in_ready);
		board.predict_port_writes(f);
	endtask

	// Lets every owed result drain, then keeps waiting so that the block is
	// certainly idle before the registers change or the run ends.
	task automatic settle();
		in_valid <= 1'b0;
		while (board.owed_writes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Main stimulus: directed corners under the reset settings, then six phases
	// of random requests, each under its own register settings, the extremes
	// among them and the reset values restored at the end.
	initial begin : stimulus
		int k;
		int p;
		board         = new();
		burst_left    = 0;
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_addr      <= REG_GAIN_CODE;
		cfg_wdata     <= '0;
		in_valid      <= 1'b0;
		frequency_khz <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < 19; k++)
			send_request(CORNER_KHZ[k]);
		settle();

		for (p = 0; p < 6; p++) begin
			case (p)
			0: apply_settings(7, 1, 7, 65535, 1'b1);
			1: apply_settings(0, 0, 0, 0, 1'b1);
			5: apply_settings(0, 0, 4, 63000, 1'b0);
			default: apply_settings($urandom_range(0, 7), $urandom_range(0, 1),
				$urandom_range(0, 7), $urandom_range(0, 65535), 1'b1);
			endcase
			repeat (PHASE_REQS) send_request(pick_frequency());
			settle();
		end

		if (board.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Receiver: checks every accepted result and chooses out_ready for the next
	// cycle. It switches between a few stall modes of random length, one of them
	// never stalling. Once, well into the run, it holds off for a long stretch
	// so that the queue fills and the block has to refuse requests.
	initial begin : receiver
		int   mode;
		int   mode_left;
		int   hold_left;
		int   results_seen;
		int   tick;
		bit   held;
		logic rdy;
		res_t got;
		mode         = 0;
		mode_left    = 0;
		hold_left    = 0;
		results_seen = 0;
		tick         = 0;
		held         = 1'b0;
		out_ready    <= 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if (out_valid && out_ready) begin
				got.port_select  = port_select;
				got.control_byte = control_byte;
				got.nib.first    = nibble_first;
				got.nib.second   = nibble_second;
				got.nib.third    = nibble_third;
				got.nib.fourth   = nibble_fourth;
				got.last         = last;
				board.check_port_write(got);
				results_seen++;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (!held && results_seen >= HOLD_AFTER) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				rdy       = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (mode)
				0: rdy = 1'b1;
				1: rdy = 1'($urandom_range(0, 1));
				2: rdy = ($urandom_range(0, 3) == 0);
				default: rdy = ((tick % 7) < 4);
				endcase
			end
			out_ready <= rdy;
		end
	end

	// Watchdog: ends the run if neither channel moves for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TEST FAILED");
		$finish;
	end

endmodule
